// File: hdl/t0ax_pkg.sv
// ----------------------------------------------------------------------------
// t0ax_pkg: shared types and constants for the T=0 APDU exchange sequencer
// Holds the action, kind and status codes, the beat layouts and the queue
// entry that links the classifier front to the beat generator back.
// ----------------------------------------------------------------------------
package t0ax_pkg;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Input actions (slave tuser)
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_HOST  = 2'd1;
    localparam logic [1:0] ACT_CARD  = 2'd2;
    localparam logic [1:0] ACT_FAIL  = 2'd3;

    // Result kinds (master tuser)
    localparam logic [1:0] KIND_TO_CARD = 2'd0;
    localparam logic [1:0] KIND_TO_HOST = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    // Completion status
    localparam logic [2:0] STATUS_OK = 3'd0;

    // Procedure byte classes that mean SW1
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] SW_CLASS_6  = 8'h60;
    localparam logic [7:0] SW_CLASS_9  = 8'h90;

    // Beat index of the final header byte
    localparam logic [2:0] HDR_LAST_NO_P3 = 3'd3;
    localparam logic [2:0] HDR_LAST_P3    = 3'd4;

    typedef enum logic {
        CMD_HDR,
        CMD_ONE
    } t_cmd_op;

    // Header: bytes = CLA, INS, P1, P2, P3.
    // Single beat: bytes[0] = out_byte, bytes[1] = sw1, bytes[2] = sw2.
    typedef struct packed {
        t_cmd_op         op;
        logic            has_p3;
        logic [1:0]      kind;
        logic [2:0]      status;
        logic [4:0][7:0] bytes;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qslot;

endpackage

// File: hdl/t0ax_front.sv
// ----------------------------------------------------------------------------
// t0ax_front: item classifier and exchange state
// Accepts one item per cycle while the queue has room, walks the T=0 exchange
// phases and pushes one command per item that yields results into the queue.
// ----------------------------------------------------------------------------
module t0ax_front import t0ax_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_q_full,
    output t_qslot               o_q_wr
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PROC,
        PH_SEND,
        PH_RECV,
        PH_SW1,
        PH_SW2
    } t_phase;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_TO_CARD,
        DIR_FROM_CARD
    } t_dir;

    t_phase     r_phase, n_phase;
    t_dir       r_dir, n_dir;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_sw1, n_sw1;

    logic       w_accept;
    logic [1:0] w_action;
    logic [7:0] w_cla, w_ins, w_p1, w_p2, w_lc, w_le, w_db;
    logic [1:0] w_fc;
    logic [7:0] w_rem_dec;
    logic [7:0] w_class;
    t_qslot     w_wr;

    // Unpack the beat
    assign w_action = i_s_tuser[1:0];
    assign w_cla    = i_s_tdata[7:0];
    assign w_ins    = i_s_tdata[15:8];
    assign w_p1     = i_s_tdata[23:16];
    assign w_p2     = i_s_tdata[31:24];
    assign w_lc     = i_s_tdata[39:32];
    assign w_le     = i_s_tdata[47:40];
    assign w_db     = i_s_tdata[55:48];
    assign w_fc     = i_s_tdata[57:56];

    // Take beats only out of reset and while the queue has room
    assign o_s_tready = i_rst_n && !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_rem_dec  = r_rem - 8'd1;
    assign w_class    = w_db & NIBBLE_MASK;
    assign o_q_wr     = w_wr;

    // Classify the item and advance the exchange
    always_comb begin
        n_phase = r_phase;
        n_dir   = r_dir;
        n_rem   = r_rem;
        n_sw1   = r_sw1;
        w_wr    = '0;
        w_wr.cmd.op = CMD_ONE;
        if (w_accept) begin
            case (w_action)
                ACT_START: begin
                    w_wr.valid        = 1'b1;
                    w_wr.cmd.op       = CMD_HDR;
                    w_wr.cmd.kind     = KIND_TO_CARD;
                    w_wr.cmd.has_p3   = (w_lc != 8'd0) || (w_le != 8'd0);
                    w_wr.cmd.bytes[0] = w_cla;
                    w_wr.cmd.bytes[1] = w_ins;
                    w_wr.cmd.bytes[2] = w_p1;
                    w_wr.cmd.bytes[3] = w_p2;
                    w_wr.cmd.bytes[4] = (w_lc != 8'd0) ? w_lc : w_le;
                    n_phase = PH_PROC;
                    n_sw1   = 8'd0;
                    if (w_lc != 8'd0) begin
                        n_dir = DIR_TO_CARD;
                        n_rem = w_lc;
                    end else if (w_le != 8'd0) begin
                        n_dir = DIR_FROM_CARD;
                        n_rem = w_le;
                    end else begin
                        n_dir = DIR_NONE;
                        n_rem = 8'd0;
                    end
                end
                ACT_FAIL: begin
                    if (r_phase != PH_IDLE) begin
                        w_wr.valid      = 1'b1;
                        w_wr.cmd.kind   = KIND_DONE;
                        w_wr.cmd.status = {1'b0, w_fc} + 3'd1;
                        n_phase = PH_IDLE;
                        n_rem   = 8'd0;
                        n_dir   = DIR_NONE;
                    end
                end
                ACT_HOST: begin
                    if (r_phase == PH_SEND) begin
                        w_wr.valid        = 1'b1;
                        w_wr.cmd.kind     = KIND_TO_CARD;
                        w_wr.cmd.bytes[0] = w_db;
                        n_rem = w_rem_dec;
                        if (w_rem_dec == 8'd0) begin
                            n_phase = PH_SW1;
                        end
                    end
                end
                ACT_CARD: begin
                    case (r_phase)
                        PH_PROC: begin
                            if (w_class == SW_CLASS_6 || w_class == SW_CLASS_9) begin
                                n_sw1   = w_db;
                                n_phase = PH_SW2;
                            end else if (r_dir == DIR_TO_CARD && r_rem != 8'd0) begin
                                n_phase = PH_SEND;
                            end else if (r_dir == DIR_FROM_CARD && r_rem != 8'd0) begin
                                n_phase = PH_RECV;
                            end else begin
                                n_phase = PH_SW1;
                            end
                        end
                        PH_RECV: begin
                            w_wr.valid        = 1'b1;
                            w_wr.cmd.kind     = KIND_TO_HOST;
                            w_wr.cmd.bytes[0] = w_db;
                            n_rem = w_rem_dec;
                            if (w_rem_dec == 8'd0) begin
                                n_phase = PH_SW1;
                            end
                        end
                        PH_SW1: begin
                            n_sw1   = w_db;
                            n_phase = PH_SW2;
                        end
                        PH_SW2: begin
                            w_wr.valid        = 1'b1;
                            w_wr.cmd.kind     = KIND_DONE;
                            w_wr.cmd.bytes[1] = r_sw1;
                            w_wr.cmd.bytes[2] = w_db;
                            n_phase = PH_IDLE;
                            n_rem   = 8'd0;
                            n_dir   = DIR_NONE;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Hold the exchange state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dir   <= DIR_NONE;
            r_rem   <= 8'd0;
            r_sw1   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_dir   <= n_dir;
            r_rem   <= n_rem;
            r_sw1   <= n_sw1;
        end
    end

    // Host bytes only move while the card takes the body
    a_host_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.valid && w_wr.cmd.op == CMD_ONE && w_wr.cmd.kind == KIND_TO_CARD)
        |-> (r_phase == PH_SEND))
        else $error("host byte forwarded outside body phase");

    // A completion always returns the exchange to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.valid && w_wr.cmd.op == CMD_ONE && w_wr.cmd.kind == KIND_DONE)
        |=> (r_phase == PH_IDLE))
        else $error("completion did not end exchange");

    // Body phases always have bytes left
    a_body_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEND || r_phase == PH_RECV) |-> (r_rem != 8'd0))
        else $error("body phase with no bytes left");

endmodule

// File: hdl/t0ax_queue.sv
// ----------------------------------------------------------------------------
// t0ax_queue: command queue between front and back
// Small register FIFO that lets the classifier and the beat generator stall
// independently of each other.
// ----------------------------------------------------------------------------
module t0ax_queue import t0ax_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qslot i_wr,
    output logic   o_full,
    output t_qslot o_head,
    input  logic   i_pop
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_count;

    assign o_full       = (r_count == QCW'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rp];

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wp] <= i_wr.cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({i_wr.valid, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.valid |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.valid && !i_pop) |=> (r_count == $past(r_count) + QCW'(1)))
        else $error("fill count did not follow a push");

endmodule

// File: hdl/t0ax_back.sv
// ----------------------------------------------------------------------------
// t0ax_back: beat generator
// Expands each queued command into result beats, one beat per cycle, into
// an output register that stalls only on the master side.
// ----------------------------------------------------------------------------
module t0ax_back import t0ax_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_qslot               i_head,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser,
    output logic                 o_m_tlast
);

    logic [2:0]           r_idx;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_tdata;
    logic [M_TUSER_W-1:0] r_tuser;
    logic                 r_tlast;

    logic                 w_load;
    logic                 w_beat_last;
    logic [M_TDATA_W-1:0] w_tdata;

    assign w_load = !r_out_valid || i_m_tready;

    // Build the beat from the queue head
    always_comb begin
        if (i_head.cmd.op == CMD_HDR) begin
            w_beat_last = i_head.cmd.has_p3 ? (r_idx == HDR_LAST_P3)
                                            : (r_idx == HDR_LAST_NO_P3);
            w_tdata = {(M_TDATA_W-8)'(0), i_head.cmd.bytes[r_idx]};
        end else begin
            w_beat_last = 1'b1;
            w_tdata = {(M_TDATA_W-27)'(0), i_head.cmd.status,
                       i_head.cmd.bytes[2], i_head.cmd.bytes[1], i_head.cmd.bytes[0]};
        end
    end

    assign o_pop = w_load && i_head.valid && w_beat_last;

    // Step through the header bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (w_load && i_head.valid) begin
            r_idx <= w_beat_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_head.valid) begin
            r_tdata <= w_tdata;
            r_tuser <= i_head.cmd.kind;
            r_tlast <= w_beat_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;
    assign o_m_tlast  = r_tlast;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= HDR_LAST_P3)
        else $error("header beat index out of range");

    a_idx_in_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> (i_head.valid && i_head.cmd.op == CMD_HDR))
        else $error("header walk without a header at queue head");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && i_head.valid && i_head.cmd.op == CMD_ONE) |-> o_pop)
        else $error("single-beat command not retired");

endmodule

// File: hdl/t0_apdu_exchange_sequencer.sv
// ----------------------------------------------------------------------------
// t0_apdu_exchange_sequencer: T=0 APDU exchange sequencer
// Sends the command header, reads the procedure byte, moves the body in
// either direction and reports the status word or a link failure.
//
//   channel  dir  tdata (low bit up)                         tuser   tlast
//   s        in   cla, ins, p1, p2, lc, le, data_byte,        action  -
//                 failure_code, zero fill to 64 bits
//   m        out  out_byte, sw1, sw2, status, zero fill to 32  kind    last
//
// An item is taken every cycle while the four-entry command queue has room.
// A start item yields four or five beats, which the beat generator issues one
// per cycle while the master side takes them, so a run of starts is paced by
// its beats; other items yield at most one beat and sustain one per cycle.
// Reset is synchronous: it clears the exchange phase, the queue and the
// output register. A master-side stall fills the queue, then drops s tready.
// ----------------------------------------------------------------------------
module t0_apdu_exchange_sequencer import t0ax_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // cla[7:0], ins[15:8], p1[23:16], p2[31:24], lc[39:32], le[47:40],
    // data_byte[55:48], failure_code[57:56], zero[63:58]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // out_byte[7:0], sw1[15:8], sw2[23:16], status[26:24], zero[31:27]
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // kind[1:0]
    output logic [M_TUSER_W-1:0] o_m_tuser,
    output logic                 o_m_tlast
);

    t_qslot w_q_wr;
    t_qslot w_q_head;
    logic   w_q_full;
    logic   w_q_pop;

    t0ax_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_q_wr     (w_q_wr)
    );

    t0ax_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .o_full  (w_q_full),
        .o_head  (w_q_head),
        .i_pop   (w_q_pop)
    );

    t0ax_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_q_head),
        .o_pop      (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
